// ===== hw/rtl/ffca_pkg.sv =====
package ffca_pkg;
  localparam int FreeSlots = 64;
  localparam int IdxW = $clog2(FreeSlots);
  localparam int CntW = $clog2(FreeSlots + 1);
  localparam logic [31:0] HeapReset = 32'h0030_0000;
  localparam logic [31:0] Hdr = 32'd4;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
  } entry_t;
endpackage

// ===== hw/rtl/ffca_req_if.sv =====
interface ffca_req_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [31:0] req_size;
  logic [31:0] user_addr;
  logic [31:0] header_size;
  modport source(output valid, cmd, req_size, user_addr, header_size, input ready);
  modport sink(input valid, cmd, req_size, user_addr, header_size, output ready);
endinterface

// ===== hw/rtl/ffca_rsp_if.sv =====
interface ffca_rsp_if;
  logic valid;
  logic ready;
  logic [31:0] result_addr;
  logic [1:0] status;
  modport source(output valid, result_addr, status, input ready);
  modport sink(input valid, result_addr, status, output ready);
endinterface

// ===== hw/rtl/ffca_cfg_if.sv =====
interface ffca_cfg_if;
  logic valid;
  logic ready;
  logic [31:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== hw/rtl/first_fit_coalescing_allocator.sv =====
// Each transaction walks the free table: allocate scans it and then shifts
// entries left; free finds its position, shifts right, writes, may shift left
// to merge and then tests the tail. The table holds at most 64 free entries.
// Throughput: one transaction at a time; the next is taken once the result
// register is empty. Synchronous active-high reset: empty table, bump
// pointer and heap base at 0x300000. Table memory needs no clearing.
module first_fit_coalescing_allocator
  import ffca_pkg::*;
(
  input logic clk,
  input logic rst,
  ffca_req_if.sink req,
  ffca_rsp_if.source rsp,
  ffca_cfg_if.sink cfg
);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SHL_RD, S_SHL_WR,
    S_INS_RD, S_INS_CHK, S_SHR_RD, S_SHR_WR, S_INS_WR,
    S_LAST_RD, S_LAST_CHK, S_DONE
  } state_t;

  // Free is done as: find position, shift right, write, then merge with the
  // next and previous neighbors via drop (shift left), then test the tail.
  entry_t mem [FreeSlots];
  entry_t rd_data;
  logic [IdxW-1:0] rd_addr;
  logic rd_en;
  logic wr_en;
  logic [IdxW-1:0] wr_addr;
  entry_t wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  state_t state;
  logic [CntW-1:0] count;
  logic [31:0] bump;
  logic cmd_r;
  logic [31:0] req_r;
  entry_t new_e;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] pos;
  entry_t prev_e;
  logic have_prev;
  logic [1:0] merge_ph;
  logic [31:0] res;
  logic [1:0] stat;
  logic out_valid;

  logic [33:0] bump_end;
  logic [33:0] new_end;
  logic [33:0] prev_end;
  logic [33:0] rd_end;
  assign bump_end = {2'b0, bump} + {2'b0, req_r} + {2'b0, Hdr};
  assign new_end = {2'b0, new_e.start} + {2'b0, new_e.size} + {2'b0, Hdr};
  assign prev_end = {2'b0, prev_e.start} + {2'b0, prev_e.size} + {2'b0, Hdr};
  assign rd_end = {2'b0, rd_data.start} + {2'b0, rd_data.size} + {2'b0, Hdr};

  assign req.ready = (state == S_IDLE) && !out_valid;
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.result_addr = res;
  assign rsp.status = stat;

  always_comb begin
    rd_en = 1'b0;
    rd_addr = idx[IdxW-1:0];
    wr_en = 1'b0;
    wr_addr = idx[IdxW-1:0];
    wr_data = rd_data;
    unique case (state)
      S_SCAN_RD, S_INS_RD, S_LAST_RD: rd_en = 1'b1;
      S_SHL_RD: begin
        rd_en = 1'b1;
        rd_addr = IdxW'(idx + 1'b1);
      end
      S_SHL_WR: wr_en = 1'b1;
      S_SHR_RD: begin
        rd_en = 1'b1;
        rd_addr = IdxW'(idx - 1'b1);
      end
      S_SHR_WR: wr_en = 1'b1;
      S_INS_WR: begin
        wr_en = 1'b1;
        wr_addr = pos[IdxW-1:0];
        wr_data = new_e;
      end
      default: ;
    endcase
  end

  // merge_ph: 0 = inserting; 1 = drop for join with next (new absorbs it);
  // 2 = drop for join with previous; 3 = done merging.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      bump <= HeapReset;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      if (cfg.valid) bump <= cfg.data;
      unique case (state)
        S_IDLE: begin
          if (req.valid && !out_valid) begin
            cmd_r <= req.cmd;
            req_r <= req.req_size;
            new_e.start <= req.user_addr - Hdr;
            new_e.size <= req.header_size;
            idx <= '0;
            have_prev <= 1'b0;
            merge_ph <= 2'd0;
            if (req.cmd == CMD_FREE && count == CntW'(FreeSlots)) begin
              res <= '0;
              stat <= ST_FULL;
              out_valid <= 1'b1;
            end else if (req.cmd == CMD_FREE) begin
              state <= (count == '0) ? S_INS_WR : S_INS_RD;
              pos <= '0;
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          if (idx == count) begin
            state <= S_DONE;
            if (bump_end[33:32] != 2'b00) begin
              res <= '0;
              stat <= ST_OVERFLOW;
            end else begin
              res <= bump + Hdr;
              stat <= ST_OK;
              bump <= bump_end[31:0];
            end
          end else begin
            state <= S_SCAN_CHK;
          end
        end
        S_SCAN_CHK: begin
          if (rd_data.size >= req_r) begin
            res <= rd_data.start + Hdr;
            stat <= ST_OK;
            state <= (CntW'(idx + 1'b1) >= count) ? S_DONE : S_SHL_RD;
            if (CntW'(idx + 1'b1) >= count) count <= count - 1'b1;
          end else begin
            idx <= idx + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_SHL_RD: state <= S_SHL_WR;
        S_SHL_WR: begin
          if (CntW'(idx + 2'd2) >= count) begin
            count <= count - 1'b1;
            if (cmd_r == CMD_ALLOC) begin
              state <= S_DONE;
            end else begin
              // after a merge, continue merge chain
              merge_ph <= merge_ph + 1'b1;
              if (merge_ph == 2'd1 && have_prev) begin
                idx <= pos;
                state <= S_INS_RD;
              end else begin
                idx <= count - 2'd2;
                state <= S_LAST_RD;
              end
            end
          end else begin
            idx <= idx + 1'b1;
            state <= S_SHL_RD;
          end
        end
        S_INS_RD: state <= S_INS_CHK;
        S_INS_CHK: begin
          if (merge_ph == 2'd0) begin
            if (rd_data.start < new_e.start) begin
              prev_e <= rd_data;
              have_prev <= 1'b1;
              pos <= idx + 1'b1;
              if (CntW'(idx + 1'b1) == count) begin
                idx <= count;
                state <= S_INS_WR;
              end else begin
                idx <= idx + 1'b1;
                state <= S_INS_RD;
              end
            end else begin
              idx <= count;
              state <= S_SHR_RD;
            end
          end else begin
            // rd_data is the block at pos (maybe merged), prev_e precedes it
            if (prev_end == {2'b0, rd_data.start}) begin
              new_e.start <= prev_e.start;
              new_e.size <= prev_e.size + rd_data.size + Hdr;
              pos <= pos - 1'b1;
              merge_ph <= 2'd2;
              state <= S_INS_WR;
            end else begin
              merge_ph <= 2'd3;
              idx <= count - 1'b1;
              state <= S_LAST_RD;
            end
          end
        end
        S_SHR_RD: state <= S_SHR_WR;
        S_SHR_WR: begin
          if (CntW'(idx - 1'b1) == pos) begin
            state <= S_INS_WR;
          end else begin
            idx <= idx - 1'b1;
            state <= S_SHR_RD;
          end
        end
        S_INS_WR: begin
          if (merge_ph == 2'd0) begin
            count <= count + 1'b1;
            if (CntW'(pos + 1'b1) < CntW'(count + 1'b1)) begin
              idx <= pos + 1'b1;
              state <= S_LAST_RD;
              merge_ph <= 2'd0;
            end else if (have_prev) begin
              merge_ph <= 2'd1;
              idx <= pos;
              state <= S_INS_RD;
            end else begin
              merge_ph <= 2'd3;
              idx <= pos;
              state <= S_LAST_RD;
            end
          end else begin
            // merged block written at pos; drop pos+1
            idx <= pos + 1'b1;
            if (CntW'(pos + 2'd2) >= count) begin
              count <= count - 1'b1;
              if (merge_ph == 2'd1 && have_prev) begin
                merge_ph <= 2'd2;
                idx <= pos;
                state <= S_INS_RD;
              end else begin
                merge_ph <= 2'd3;
                idx <= count - 2'd2;
                state <= S_LAST_RD;
              end
            end else begin
              state <= S_SHL_RD;
            end
          end
        end
        S_LAST_RD: state <= S_LAST_CHK;
        S_LAST_CHK: begin
          if (merge_ph == 2'd0) begin
            // rd_data is the entry after the new block
            if (new_end == {2'b0, rd_data.start}) begin
              new_e.size <= new_e.size + rd_data.size + Hdr;
              merge_ph <= 2'd1;
              state <= S_INS_WR;
            end else if (have_prev) begin
              merge_ph <= 2'd1;
              idx <= pos;
              state <= S_INS_RD;
            end else begin
              merge_ph <= 2'd3;
              idx <= count - 1'b1;
              state <= S_LAST_RD;
            end
          end else begin
            if (rd_end == {2'b0, bump}) begin
              bump <= rd_data.start;
              count <= count - 1'b1;
            end
            res <= '0;
            stat <= ST_OK;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
